// ===== hw/rtl/scz_pkg.sv =====
// Shared sizes and register indexes for the staggered-grid curl stencil.
// No dependencies; used by scz_divider and staggered_curl_z_stencil.
package scz_pkg;

    // Grid limits
    localparam int MAX_ROW_LENGTH = 1024;
    localparam int MAX_ROWS       = 1024;
    localparam int COL_W          = $clog2(MAX_ROW_LENGTH);
    localparam int ROW_W          = $clog2(MAX_ROWS);

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_PLANE = 1'd1;
    localparam logic [CFG_W-1:0]     CFG_RESET          = 11'd1024;

    // Field widths
    localparam int VEL_W    = 24;
    localparam int CRD_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int S_DATA_W = 2 * VEL_W + 2 * CRD_W;
    localparam int RES_W    = 32;

    // Divider sizes: scaled velocity difference over coordinate difference
    localparam int NUM_W = VEL_W + 1 + FRAC_W;
    localparam int DEN_W = CRD_W + 1;
    localparam int QUO_W = NUM_W + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);

endpackage

// ===== hw/rtl/scz_divider.sv =====
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on scz_pkg for operand widths.
module scz_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [scz_pkg::NUM_W-1:0]  i_num,
    input  logic signed [scz_pkg::DEN_W-1:0]  i_den,
    output logic                              o_done,
    output logic signed [scz_pkg::QUO_W-1:0]  o_quo
);

    logic                           r_busy;
    logic                           r_done;
    logic [scz_pkg::CNT_W-1:0]      r_cnt;
    logic                           r_neg;
    logic [scz_pkg::NUM_W-1:0]      r_quo;
    logic [scz_pkg::DEN_W-1:0]      r_rem;
    logic [scz_pkg::DEN_W-1:0]      r_den;

    logic [scz_pkg::NUM_W-1:0]      num_abs;
    logic [scz_pkg::DEN_W-1:0]      den_abs;
    logic [scz_pkg::DEN_W:0]        trial;
    logic [scz_pkg::DEN_W+1:0]      diff;
    logic                           qbit;

    // operand magnitudes
    assign num_abs = i_num[scz_pkg::NUM_W-1] ? scz_pkg::NUM_W'(-i_num) : i_num;
    assign den_abs = i_den[scz_pkg::DEN_W-1] ? scz_pkg::DEN_W'(-i_den) : i_den;

    // one restoring step: shift in the next dividend bit, try the subtract
    assign trial = {r_rem, r_quo[scz_pkg::NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_den};
    assign qbit  = ~diff[scz_pkg::DEN_W+1];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= scz_pkg::CNT_W'(scz_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == scz_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[scz_pkg::NUM_W-1] ^ i_den[scz_pkg::DEN_W-1];
            r_quo <= num_abs;
            r_rem <= '0;
            r_den <= den_abs;
        end else if (r_busy) begin
            r_quo <= {r_quo[scz_pkg::NUM_W-2:0], qbit};
            if (qbit) begin
                r_rem <= diff[scz_pkg::DEN_W-1:0];
            end else begin
                r_rem <= trial[scz_pkg::DEN_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

// ===== hw/rtl/staggered_curl_z_stencil.sv =====
// Staggered-grid z-vorticity stencil top level; depends on scz_pkg and scz_divider.
// An interior beat passes the read, divide and output states to the output register
// (no divide on zero spacing); a ghost beat returns to idle after read. A new beat is
// taken only in idle; the bit-serial dividers give 41 quotient bits, one per cycle.
// Reset (synchronous, active low) clears positions and neighbour registers and
// sets both size registers to 1024; the row store is not cleared.
module staggered_curl_z_stencil (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [scz_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scz_pkg::CFG_W-1:0]         i_cfg_data,
    // cell stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // x_velocity [23:0], y_velocity [47:24], column_coord [79:48], row_coord [111:80]
    input  logic [scz_pkg::S_DATA_W-1:0]      s_tdata,
    // result stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // vorticity [31:0]
    output logic [scz_pkg::RES_W-1:0]         m_tdata,
    // overflow [0]
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam int VW = scz_pkg::VEL_W;
    localparam int CW = scz_pkg::CRD_W;

    logic [1:0]                  r_state;
    logic [scz_pkg::CFG_W-1:0]   r_row_length;
    logic [scz_pkg::CFG_W-1:0]   r_rows_per_plane;
    logic [scz_pkg::COL_W-1:0]   r_col_pos;
    logic [scz_pkg::ROW_W-1:0]   r_row_pos;
    logic signed [VW-1:0]        r_left_uy;
    logic signed [CW-1:0]        r_left_xc;
    logic signed [CW-1:0]        r_above_yc;

    // latched beat
    logic signed [VW-1:0]        r_ux;
    logic signed [VW-1:0]        r_uy;
    logic signed [CW-1:0]        r_xc;
    logic signed [CW-1:0]        r_yc;
    logic [scz_pkg::COL_W-1:0]   r_col;
    logic [scz_pkg::ROW_W-1:0]   r_row;
    logic                        r_row_end;
    logic                        r_plane_end;

    // row store
    logic signed [VW-1:0]        r_mem [scz_pkg::MAX_ROW_LENGTH];
    logic signed [VW-1:0]        r_ux_above;

    // pending result
    logic [scz_pkg::RES_W-1:0]   r_res;
    logic                        r_res_ovf;

    // output register
    logic                        r_m_tvalid;
    logic [scz_pkg::RES_W-1:0]   r_m_tdata;
    logic                        r_m_tuser;
    logic                        r_m_tlast;

    logic [scz_pkg::CFG_W-1:0]   len_eff;
    logic [scz_pkg::CFG_W-1:0]   rows_eff;
    logic [scz_pkg::COL_W-1:0]   col_last;
    logic [scz_pkg::ROW_W-1:0]   row_last;
    logic [scz_pkg::COL_W-1:0]   col_eff;
    logic [scz_pkg::ROW_W-1:0]   row_eff;
    logic                        accept;
    logic                        interior;
    logic signed [CW:0]          dx;
    logic signed [CW:0]          dy;
    logic signed [VW:0]          dv;
    logic signed [VW:0]          du;
    logic signed [scz_pkg::NUM_W-1:0] num_v;
    logic signed [scz_pkg::NUM_W-1:0] num_u;
    logic                        div_start;
    logic                        done_v;
    logic                        done_u;
    logic signed [scz_pkg::QUO_W-1:0] quo_v;
    logic signed [scz_pkg::QUO_W-1:0] quo_u;
    logic signed [scz_pkg::QUO_W:0]   w;
    logic                        w_sat;
    logic                        out_free;

    // effective geometry, registers saturated to their legal range
    always_comb begin
        if (r_row_length < scz_pkg::CFG_W'(2)) begin
            len_eff = scz_pkg::CFG_W'(2);
        end else if (r_row_length > scz_pkg::CFG_W'(scz_pkg::MAX_ROW_LENGTH)) begin
            len_eff = scz_pkg::CFG_W'(scz_pkg::MAX_ROW_LENGTH);
        end else begin
            len_eff = r_row_length;
        end
        if (r_rows_per_plane < scz_pkg::CFG_W'(2)) begin
            rows_eff = scz_pkg::CFG_W'(2);
        end else if (r_rows_per_plane > scz_pkg::CFG_W'(scz_pkg::MAX_ROWS)) begin
            rows_eff = scz_pkg::CFG_W'(scz_pkg::MAX_ROWS);
        end else begin
            rows_eff = r_rows_per_plane;
        end
    end

    assign col_last = scz_pkg::COL_W'(len_eff - 1'b1);
    assign row_last = scz_pkg::ROW_W'(rows_eff - 1'b1);
    assign col_eff  = (r_col_pos > col_last) ? col_last : r_col_pos;
    assign row_eff  = (r_row_pos > row_last) ? row_last : r_row_pos;

    assign s_tready = (r_state == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = ~r_m_tvalid | m_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length     <= scz_pkg::CFG_RESET;
            r_rows_per_plane <= scz_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                scz_pkg::CFG_ROW_LENGTH:     r_row_length     <= i_cfg_data;
                scz_pkg::CFG_ROWS_PER_PLANE: r_rows_per_plane <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // row store: read at accept, write back the new x-velocity in the cycle after
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ux_above <= r_mem[col_eff];
        end
        if (r_state == S_READ) begin
            r_mem[r_col] <= r_ux;
        end
    end

    // beat capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ux        <= s_tdata[VW-1:0];
            r_uy        <= s_tdata[2*VW-1:VW];
            r_xc        <= s_tdata[2*VW+CW-1:2*VW];
            r_yc        <= s_tdata[2*VW+2*CW-1:2*VW+CW];
            r_col       <= col_eff;
            r_row       <= row_eff;
            r_row_end   <= (col_eff == col_last);
            r_plane_end <= (col_eff == col_last) && (row_eff == row_last);
        end
    end

    // differences against the neighbours
    assign interior  = (r_col != '0) && (r_row != '0);
    assign dx        = $signed({r_xc[CW-1], r_xc}) - $signed({r_left_xc[CW-1], r_left_xc});
    assign dy        = $signed({r_yc[CW-1], r_yc}) - $signed({r_above_yc[CW-1], r_above_yc});
    assign dv        = $signed({r_uy[VW-1], r_uy}) - $signed({r_left_uy[VW-1], r_left_uy});
    assign du        = $signed({r_ux[VW-1], r_ux}) - $signed({r_ux_above[VW-1], r_ux_above});
    assign num_v     = {dv, {scz_pkg::FRAC_W{1'b0}}};
    assign num_u     = {du, {scz_pkg::FRAC_W{1'b0}}};
    assign div_start = (r_state == S_READ) && interior && (dx != '0) && (dy != '0);

    scz_divider u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_v),
        .i_den   (dx),
        .o_done  (done_v),
        .o_quo   (quo_v)
    );

    scz_divider u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_u),
        .i_den   (dy),
        .o_done  (done_u),
        .o_quo   (quo_u)
    );

    // exact difference of the quotients, then saturation
    assign w     = $signed({quo_v[scz_pkg::QUO_W-1], quo_v})
                 - $signed({quo_u[scz_pkg::QUO_W-1], quo_u});
    assign w_sat = (w[scz_pkg::QUO_W:scz_pkg::RES_W-1] != '0)
                && (w[scz_pkg::QUO_W:scz_pkg::RES_W-1] != '1);

    // sequencer and neighbour state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_col_pos  <= '0;
            r_row_pos  <= '0;
            r_left_uy  <= '0;
            r_left_xc  <= '0;
            r_above_yc <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_left_uy <= r_uy;
                    r_left_xc <= r_xc;
                    if (r_row_end) begin
                        r_above_yc <= r_yc;
                        r_col_pos  <= '0;
                        r_row_pos  <= r_plane_end ? '0 : r_row + 1'b1;
                    end else begin
                        r_col_pos <= r_col + 1'b1;
                        r_row_pos <= r_row;
                    end
                    if (!interior) begin
                        r_state <= S_IDLE;
                    end else if (div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (done_v) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // pending result: zero spacing flags at once, else from the dividers
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_res     <= '0;
            r_res_ovf <= 1'b1;
        end else if ((r_state == S_DIV) && done_v) begin
            if (!w_sat) begin
                r_res <= w[scz_pkg::RES_W-1:0];
            end else if (w[scz_pkg::QUO_W]) begin
                r_res <= {1'b1, {(scz_pkg::RES_W-1){1'b0}}};
            end else begin
                r_res <= {1'b0, {(scz_pkg::RES_W-1){1'b1}}};
            end
            r_res_ovf <= w_sat;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_m_tdata <= r_res;
            r_m_tuser <= r_res_ovf;
            r_m_tlast <= r_plane_end;
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;
    assign m_tlast  = r_m_tlast;

    // both dividers run in lockstep
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_v == done_u)
        else $error("divider completions out of step");

    // a quotient only arrives while a division is awaited
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_v |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    // the latched column never passes the row end
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_col <= col_last))
        else $error("column index beyond row end");

    // a result is only loaded from the output state
    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_m_tvalid && $past(1'b1) ##1 r_m_tvalid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside the output state");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for staggered_curl_z_stencil: streams grid cells in, checks each
// vorticity beat against a built-in predictor of the first-order staggered curl.
// Depends on scz_pkg and the stencil RTL with its divider.
module tb;

    localparam int RANDOM_ITEMS   = 650;
    localparam int SETTLE_CYCLES  = 60;     // longest interior latency plus margin
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTED    = 50;

    localparam logic [scz_pkg::VEL_W-1:0] VEL_MAX = 24'h7F_FFFF;
    localparam logic [scz_pkg::VEL_W-1:0] VEL_MIN = 24'h80_0000;
    localparam logic [scz_pkg::CRD_W-1:0] CRD_MAX = 32'h7FFF_FFFF;
    localparam logic [scz_pkg::CRD_W-1:0] CRD_MIN = 32'h8000_0000;
    localparam longint RES_MAX = 64'sh7FFF_FFFF;
    localparam longint RES_MIN = -64'sh8000_0000;

    // Packed so that the cell maps straight onto s_tdata: ux lowest, yc highest
    typedef struct packed {
        logic [scz_pkg::CRD_W-1:0] yc;
        logic [scz_pkg::CRD_W-1:0] xc;
        logic [scz_pkg::VEL_W-1:0] uy;
        logic [scz_pkg::VEL_W-1:0] ux;
    } t_cell_beat;

    typedef struct {
        logic [scz_pkg::RES_W-1:0] vorticity;
        logic                      overflow;
        logic                      last_of_plane;
    } t_vorticity;

    // DUT signals; the inputs are all known from time zero
    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [scz_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [scz_pkg::CFG_W-1:0]     i_cfg_data  = '0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [scz_pkg::S_DATA_W-1:0]  s_tdata     = '0;
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [scz_pkg::RES_W-1:0]     m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;

    // Predictor state
    logic [scz_pkg::VEL_W-1:0]     above_ux [scz_pkg::MAX_ROW_LENGTH];
    logic [scz_pkg::VEL_W-1:0]     left_uy        = '0;
    logic [scz_pkg::CRD_W-1:0]     left_xc        = '0;
    logic [scz_pkg::CRD_W-1:0]     above_yc       = '0;
    int unsigned                   next_col       = 0;
    int unsigned                   next_row       = 0;
    logic [scz_pkg::CFG_W-1:0]     row_length_reg = scz_pkg::CFG_RESET;
    logic [scz_pkg::CFG_W-1:0]     rows_reg       = scz_pkg::CFG_RESET;
    t_vorticity                    vorticity_q[$];

    // Random grid shape for the well-formed part of the stream
    logic [scz_pkg::CRD_W-1:0]     grid_x0, grid_y0, grid_sx, grid_sy;

    // Idling controls and bookkeeping
    bit                   src_idle   = 1'b1;
    bit                   sink_idle  = 1'b1;
    int unsigned          sink_hold  = 0;
    int unsigned          idle_cycles = 0;
    int unsigned          n_errors = 0, n_beats = 0, n_results = 0;
    int unsigned          n_overflow = 0, n_plane_ends = 0, n_cfg_writes = 0;
    t_vorticity           want;

    staggered_curl_z_stencil u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned clamp_size(input logic [scz_pkg::CFG_W-1:0] v,
                                               input int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    // Position of the next cell; a position past a shrunk size sits on the last index
    function automatic void where_next(output int unsigned col, output int unsigned row);
        int unsigned len, rows;
        len  = clamp_size(row_length_reg, scz_pkg::MAX_ROW_LENGTH);
        rows = clamp_size(rows_reg, scz_pkg::MAX_ROWS);
        col  = (next_col > len - 1) ? len - 1 : next_col;
        row  = (next_row > rows - 1) ? rows - 1 : next_row;
    endfunction

    // Advances the grid state by one cell; returns 1 when the cell is interior
    function automatic bit predict_vorticity(input t_cell_beat c, output t_vorticity r);
        int unsigned col, row, len, rows;
        bit row_end, plane_end;
        longint dx, dy, dv, du, w;
        where_next(col, row);
        len       = clamp_size(row_length_reg, scz_pkg::MAX_ROW_LENGTH);
        rows      = clamp_size(rows_reg, scz_pkg::MAX_ROWS);
        row_end   = (col == len - 1);
        plane_end = row_end && (row == rows - 1);

        dx = longint'($signed(c.xc)) - longint'($signed(left_xc));
        dy = longint'($signed(c.yc)) - longint'($signed(above_yc));
        dv = longint'($signed(c.uy)) - longint'($signed(left_uy));
        du = longint'($signed(c.ux)) - longint'($signed(above_ux[col]));
        w  = 0;
        r.overflow = 1'b0;
        if (dx == 0 || dy == 0) begin
            r.overflow = 1'b1;
        end else begin
            // Q16.16 quotients, each truncated toward zero, then saturated
            w = (dv * 65536) / dx - (du * 65536) / dy;
            if (w > RES_MAX) begin
                w = RES_MAX;
                r.overflow = 1'b1;
            end else if (w < RES_MIN) begin
                w = RES_MIN;
                r.overflow = 1'b1;
            end
        end
        r.vorticity     = w[scz_pkg::RES_W-1:0];
        r.last_of_plane = plane_end;

        above_ux[col] = c.ux;
        left_uy       = c.uy;
        left_xc       = c.xc;
        if (row_end) begin
            above_yc = c.yc;
            next_col = 0;
            next_row = plane_end ? 0 : row + 1;
        end else begin
            next_col = col + 1;
            next_row = row;
        end
        return (row != 0 && col != 0);
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int unsigned pick_gap(input bit on);
        int unsigned r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic int unsigned pick_stall();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly small grids so planes close often; now and then the out-of-range extremes
    function automatic logic [scz_pkg::CFG_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            case ($urandom_range(0, 3))
                0:       return 11'd0;
                1:       return 11'd1;
                2:       return 11'd1024;
                default: return 11'h7FF;
            endcase
        end
        if (r < 80) return scz_pkg::CFG_W'($urandom_range(2, 8));
        return scz_pkg::CFG_W'($urandom_range(9, 48));
    endfunction

    function automatic logic [scz_pkg::CRD_W-1:0] pick_spacing();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 60) return ($urandom_range(0, 1) != 0)
                           ? scz_pkg::CRD_W'($urandom_range(1, 1 << 17))
                           : -scz_pkg::CRD_W'($urandom_range(1, 1 << 17));
        return $urandom;
    endfunction

    function automatic t_cell_beat random_cell();
        t_cell_beat c;
        c.ux = scz_pkg::VEL_W'($urandom);
        c.uy = scz_pkg::VEL_W'($urandom);
        c.xc = $urandom;
        c.yc = $urandom;
        return c;
    endfunction

    // Most cells sit on a regular grid, half of those with modest velocities; the rest are noise
    function automatic t_cell_beat grid_cell();
        t_cell_beat c;
        int unsigned col, row;
        c = random_cell();
        if ($urandom_range(0, 9) < 6) begin
            where_next(col, row);
            c.xc = grid_x0 + col * grid_sx;
            c.yc = grid_y0 + row * grid_sy;
            if ($urandom_range(0, 1) == 0) begin
                c.ux = scz_pkg::VEL_W'($urandom_range(0, 1 << 17))
                     - scz_pkg::VEL_W'(1 << 16);
                c.uy = scz_pkg::VEL_W'($urandom_range(0, 1 << 17))
                     - scz_pkg::VEL_W'(1 << 16);
            end
        end
        return c;
    endfunction

    // ---------------------------------------------------------------- bus tasks

    // Called just after a rising edge; returns at the edge where the beat is taken
    task automatic send_cell(input t_cell_beat c);
        int unsigned gap;
        t_vorticity r;
        gap = pick_gap(src_idle);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge i_clk); while (!s_tready);
        n_beats++;
        if (predict_vorticity(c, r)) vorticity_q.push_back(r);
    endtask

    task automatic write_reg(input logic [scz_pkg::CFG_IDX_W-1:0] idx,
                             input logic [scz_pkg::CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == scz_pkg::CFG_ROW_LENGTH) row_length_reg = val;
        else rows_reg = val;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_cfg_writes++;
    endtask

    // Stop sending, wait for every predicted beat, optionally let a ghost beat settle
    task automatic drain(input bit settle);
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (vorticity_q.size() != 0);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Pad with random cells until the next `room` cells are all interior in one row
    task automatic to_interior(input int unsigned room);
        int unsigned col, row;
        forever begin
            where_next(col, row);
            if (row != 0 && col != 0 &&
                col + room <= clamp_size(row_length_reg, scz_pkg::MAX_ROW_LENGTH))
                break;
            send_cell(random_cell());
        end
    endtask

    task automatic report_mismatch(input string what,
                                   input logic [scz_pkg::RES_W-1:0] want_v,
                                   input logic [scz_pkg::RES_W-1:0] got_v);
        if (n_errors < MAX_PRINTED)
            $display("%0t: mismatch on %s, expected %h, got %h", $time, what, want_v, got_v);
        n_errors++;
    endtask

    // ---------------------------------------------------------------- result side

    // Receiver stalls: one registered ready, random holds when enabled
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (sink_idle && $urandom_range(0, 3) == 0) sink_hold <= pick_stall();
        end
    end

    // Compare every accepted result beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            n_results++;
            if (vorticity_q.size() == 0) begin
                report_mismatch("result beat with nothing predicted", '0, m_tdata);
            end else begin
                want = vorticity_q.pop_front();
                if (m_tdata !== want.vorticity)
                    report_mismatch("vorticity", want.vorticity, m_tdata);
                if (m_tuser !== want.overflow)
                    report_mismatch("overflow", scz_pkg::RES_W'(want.overflow),
                                    scz_pkg::RES_W'(m_tuser));
                if (m_tlast !== want.last_of_plane)
                    report_mismatch("last_of_plane", scz_pkg::RES_W'(want.last_of_plane),
                                    scz_pkg::RES_W'(m_tlast));
                n_overflow   += want.overflow;
                n_plane_ends += want.last_of_plane;
            end
        end
    end

    // Watchdog: too long with no beat on either side and no register write
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- tests

    // At reset sizes the first row is all ghost cells, so every row-store entry is
    // written before any interior cell reads it; then a few interior cells of row 1
    task automatic test_row_store_prime();
        repeat (scz_pkg::MAX_ROW_LENGTH + 4) send_cell(random_cell());
    endtask

    // Shrink sizes mid-plane: the position past the new end is taken as the last index
    task automatic test_mid_plane_wrap();
        drain(1);
        write_reg(scz_pkg::CFG_ROW_LENGTH, 11'd3);
        send_cell(random_cell());
        drain(1);
        write_reg(scz_pkg::CFG_ROWS_PER_PLANE, 11'd2);
        repeat (3) send_cell(random_cell());
    endtask

    // Out-of-range sizes: below two and above the maximum both clamp
    task automatic test_clamped_sizes();
        drain(1);
        write_reg(scz_pkg::CFG_ROW_LENGTH, 11'd0);
        write_reg(scz_pkg::CFG_ROWS_PER_PLANE, 11'd1);
        repeat (8) send_cell(random_cell());
        drain(1);
        write_reg(scz_pkg::CFG_ROW_LENGTH, 11'd1);
        write_reg(scz_pkg::CFG_ROWS_PER_PLANE, 11'd0);
        repeat (4) send_cell(random_cell());
        drain(1);
        write_reg(scz_pkg::CFG_ROW_LENGTH, 11'h7FF);
        write_reg(scz_pkg::CFG_ROWS_PER_PLANE, 11'h7FF);
        repeat (3) send_cell(random_cell());
    endtask

    // Zero spacing, saturation both ways, widest coordinate step, all-zero/all-one cells
    task automatic test_special_values();
        t_cell_beat c;
        int unsigned col, row;
        drain(1);
        write_reg(scz_pkg::CFG_ROW_LENGTH, 11'd8);
        write_reg(scz_pkg::CFG_ROWS_PER_PLANE, 11'd4);

        // zero column spacing, zero row spacing, then both
        to_interior(1);
        c = random_cell();
        c.xc = left_xc;
        send_cell(c);
        to_interior(1);
        c = random_cell();
        c.yc = above_yc;
        send_cell(c);
        to_interior(1);
        c = random_cell();
        c.xc = left_xc;
        c.yc = above_yc;
        send_cell(c);

        // full-scale velocity step over the finest column spacing, upward
        to_interior(2);
        c = random_cell();
        c.uy = VEL_MIN;
        send_cell(c);
        where_next(col, row);
        c = random_cell();
        c.uy = VEL_MAX;
        c.ux = above_ux[col];
        c.xc = left_xc + 1;
        c.yc = above_yc + 1;
        send_cell(c);

        // and downward
        to_interior(2);
        c = random_cell();
        c.uy = VEL_MAX;
        send_cell(c);
        where_next(col, row);
        c = random_cell();
        c.uy = VEL_MIN;
        c.ux = above_ux[col];
        c.xc = left_xc + 1;
        c.yc = above_yc + 1;
        send_cell(c);

        // coordinates at both ends of their range
        to_interior(2);
        c = random_cell();
        c.xc = CRD_MAX;
        c.uy = VEL_MAX;
        send_cell(c);
        c = random_cell();
        c.xc = CRD_MIN;
        c.yc = above_yc ^ CRD_MIN;
        c.uy = VEL_MIN;
        send_cell(c);

        // row term alone saturates: unit row spacing, flat y-velocity
        to_interior(1);
        where_next(col, row);
        c = random_cell();
        c.ux = above_ux[col] ^ VEL_MIN;
        c.uy = left_uy;
        c.xc = left_xc + 32'h0001_0000;
        c.yc = above_yc + 1;
        send_cell(c);

        to_interior(1);
        send_cell('0);
        to_interior(1);
        send_cell('1);
    endtask

    // Random planes: a fresh size and grid per segment, idling mode chosen per segment
    task automatic test_random_planes();
        int unsigned sent, seg;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            drain(1);
            write_reg(scz_pkg::CFG_ROW_LENGTH, pick_size());
            write_reg(scz_pkg::CFG_ROWS_PER_PLANE, pick_size());
            grid_x0   = $urandom;
            grid_y0   = $urandom;
            grid_sx   = pick_spacing();
            grid_sy   = pick_spacing();
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            seg       = $urandom_range(40, 200);
            repeat (seg) begin
                send_cell(grid_cell());
                sent++;
                // once, mid-plane: hold the sender until the pipeline is empty
                if (!paused && sent >= RANDOM_ITEMS / 2) begin
                    drain(0);
                    paused = 1'b1;
                end
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_row_store_prime();
        test_mid_plane_wrap();
        test_clamped_sizes();
        test_special_values();
        test_random_planes();
        drain(1);

        $display("Sent %0d cell beats and checked %0d vorticity beats over %0d register writes.",
                 n_beats, n_results, n_cfg_writes);
        $display("Of those, %0d flagged overflow or zero spacing and %0d closed a plane.",
                 n_overflow, n_plane_ends);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
